// ===== rtl/grcs_pkg.sv =====
package grcs_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [30:0] GRID_RESET = 31'd65536;

   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 48;
   localparam int CNT_W      = 6;

   typedef struct packed {
      logic               command;
      logic signed [15:0] start_cell_x;
      logic signed [15:0] start_cell_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic [31:0]        travel_distance;
   } rsp_type;

   typedef struct packed {
      logic go;
      logic root;
   } iter_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Z,
      ST_ROOT,
      ST_DIV_X,
      ST_DIV_Z,
      ST_INV_X,
      ST_INV_Z,
      ST_EDGE_X,
      ST_EDGE_Z,
      ST_EDGE_DONE,
      ST_CAND_X,
      ST_CAND_Z,
      ST_PICK,
      ST_MOVE_X,
      ST_MOVE_Z,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v[31:0] + 32'd1) : v[31:0];
   endfunction

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      return v[15] ? (~v[15:0] + 16'd1) : v[15:0];
   endfunction

   // candidate distance from inv*edge product
   function automatic logic [31:0] cand(input logic signed [63:0] p, input logic live);
      logic [31:0] r;
      if (!live) begin
         r = 32'hFFFFFFFF;
      end else if (p[63] || p == 64'sd0) begin
         r = 32'h0;
      end else if (p[62:48] != 15'd0) begin
         r = 32'hFFFFFFFF;
      end else begin
         r = p[47:16];
      end
      return r;
   endfunction

endpackage

// ===== rtl/grcs_iter_unit.sv =====
module grcs_iter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  grcs_pkg::iter_ctl_type ctl,
   input  logic [63:0]           num,
   input  logic [31:0]           den,
   output logic                  done,
   output logic [47:0]           result
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [grcs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       root_ff, root_in;
   logic [35:0]                rem_ff, rem_in;
   logic [63:0]                work_ff, work_in;
   logic [47:0]                res_ff, res_in;
   logic [31:0]                den_ff, den_in;

   logic [35:0] sh;
   logic [35:0] trial;
   logic [36:0] diff;
   logic        ge;

   // one restoring step: divide takes one numerator bit, root takes two
   always_comb begin
      sh    = root_ff ? {rem_ff[33:0], work_ff[63:62]} : {rem_ff[34:0], work_ff[63]};
      trial = root_ff ? {2'b00, res_ff[31:0], 2'b01} : {4'h0, den_ff};
      diff  = {1'b0, sh} - {1'b0, trial};
      ge    = !diff[36];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      if (ctl.go) begin
         busy_in = 1'b1;
         root_in = ctl.root;
         cnt_in  = ctl.root ? grcs_pkg::CNT_W'(grcs_pkg::ROOT_STEPS - 1)
                            : grcs_pkg::CNT_W'(grcs_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         res_in  = '0;
         work_in = ctl.root ? num : {num[47:0], 16'h0};
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[35:0] : sh;
         res_in  = {res_ff[46:0], ge};
         work_in = root_ff ? {work_ff[61:0], 2'b00} : {work_ff[62:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      work_ff <= work_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/grid_ray_cell_stepper.sv =====
// channel | direction | ports                          | accepted when
// req     | in        | req_valid, req_stall, req_data | req_valid && !req_stall
// rsp     | out       | rsp_valid, rsp_stall, rsp_data | rsp_valid && !rsp_stall
// csr     | in        | csr_write_en, csr_write_data   | csr_write_en
//
// One item at a time; req_stall stays high from acceptance until its result is taken.
// Start item: runs the 32-step square root and four 48-step divides
// that share one iterative subtract unit. Step item: runs on the shared multiplier.
// Synchronous reset clears the walk state and sets grid spacing to 1.0.
// A stalled result holds in the output stage; the block waits there.
module grid_ray_cell_stepper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  grcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output grcs_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [30:0]       csr_write_data
);

   grcs_pkg::state_type state_ff, state_in;

   logic [30:0]         grid_ff;
   grcs_pkg::req_type   req_ff, req_in;
   logic [63:0]         sqx_ff, sqx_in;
   logic [31:0]         len_ff, len_in;
   logic signed [15:0]  ux_ff, ux_in, uz_ff, uz_in;
   logic signed [31:0]  invx_ff, invx_in, invz_ff, invz_in;
   logic signed [31:0]  edgex_ff, edgex_in, edgez_ff, edgez_in;
   logic [15:0]         cellx_ff, cellx_in, celly_ff, celly_in;
   logic [3:0]          signs_ff, signs_in;
   logic [31:0]         tx_ff, tx_in, travel_ff, travel_in, movex_ff, movex_in;
   logic                pickx_ff, pickx_in;
   logic                launched_ff, launched_in;
   logic signed [67:0]  prod_ff, prod_in;

   logic signed [33:0]     mul_a, mul_b;
   grcs_pkg::iter_ctl_type iter_ctl;
   logic [63:0]            iter_num;
   logic [31:0]            iter_den;
   logic                   iter_done;
   logic [47:0]            iter_res;

   logic        accept;
   logic [31:0] magx, magz;
   logic [15:0] mux, muz;
   logic [31:0] ty;
   logic        pick;
   logic        iter_state;

   assign accept = req_valid && !req_stall;
   assign magx   = grcs_pkg::mag32(req_ff.dir_x);
   assign magz   = grcs_pkg::mag32(req_ff.dir_z);
   assign mux    = grcs_pkg::mag16(ux_ff);
   assign muz    = grcs_pkg::mag16(uz_ff);
   assign ty     = grcs_pkg::cand(prod_ff[63:0], uz_ff != 16'sd0);
   assign pick   = (ux_ff != 16'sd0) && ((uz_ff == 16'sd0) || (tx_ff < ty));
   assign iter_state = (state_ff == grcs_pkg::ST_ROOT) || (state_ff == grcs_pkg::ST_DIV_X) ||
                       (state_ff == grcs_pkg::ST_DIV_Z) || (state_ff == grcs_pkg::ST_INV_X) ||
                       (state_ff == grcs_pkg::ST_INV_Z);

   grcs_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .num    (iter_num),
      .den    (iter_den),
      .done   (iter_done),
      .result (iter_res)
   );

   // rounded quotient -> Q1.15 unit component
   function automatic logic signed [15:0] unit_from(input logic [47:0] q,
                                                    input logic zero_len,
                                                    input logic neg);
      logic [15:0] m;
      m = (q[47:15] != 33'd0) ? 16'd32767 : {1'b0, q[14:0]};
      if (zero_len) begin
         m = 16'd0;
      end
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] inv_from(input logic [47:0] q,
                                                   input logic signed [15:0] u);
      logic [31:0] m;
      m = (q[47:31] != 17'd0) ? 32'h7FFFFFFF : q[31:0];
      if (u == 16'sd0) begin
         m = 32'h7FFFFFFF;
      end
      return u[15] ? -$signed(m) : $signed(m);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grcs_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.command == grcs_pkg::CMD_START) ? grcs_pkg::ST_SQ_X
                                                                    : grcs_pkg::ST_CAND_X;
            end
         end
         grcs_pkg::ST_SQ_X:      state_in = grcs_pkg::ST_SQ_Z;
         grcs_pkg::ST_SQ_Z:      state_in = grcs_pkg::ST_ROOT;
         grcs_pkg::ST_ROOT:      if (iter_done) state_in = grcs_pkg::ST_DIV_X;
         grcs_pkg::ST_DIV_X:     if (iter_done) state_in = grcs_pkg::ST_DIV_Z;
         grcs_pkg::ST_DIV_Z:     if (iter_done) state_in = grcs_pkg::ST_INV_X;
         grcs_pkg::ST_INV_X:     if (iter_done) state_in = grcs_pkg::ST_INV_Z;
         grcs_pkg::ST_INV_Z:     if (iter_done) state_in = grcs_pkg::ST_EDGE_X;
         grcs_pkg::ST_EDGE_X:    state_in = grcs_pkg::ST_EDGE_Z;
         grcs_pkg::ST_EDGE_Z:    state_in = grcs_pkg::ST_EDGE_DONE;
         grcs_pkg::ST_EDGE_DONE: state_in = grcs_pkg::ST_RESULT;
         grcs_pkg::ST_CAND_X:    state_in = grcs_pkg::ST_CAND_Z;
         grcs_pkg::ST_CAND_Z:    state_in = grcs_pkg::ST_PICK;
         grcs_pkg::ST_PICK:      state_in = grcs_pkg::ST_MOVE_X;
         grcs_pkg::ST_MOVE_X:    state_in = grcs_pkg::ST_MOVE_Z;
         grcs_pkg::ST_MOVE_Z:    state_in = grcs_pkg::ST_UPDATE;
         grcs_pkg::ST_UPDATE:    state_in = grcs_pkg::ST_RESULT;
         grcs_pkg::ST_RESULT:    if (!rsp_stall) state_in = grcs_pkg::ST_IDLE;
         default:                state_in = grcs_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake, multiplier operands, iterative unit control
   always_comb begin
      req_stall     = state_ff != grcs_pkg::ST_IDLE;
      rsp_valid     = state_ff == grcs_pkg::ST_RESULT;
      mul_a         = '0;
      mul_b         = '0;
      iter_ctl.go   = iter_state && !launched_ff && !iter_done;
      iter_ctl.root = state_ff == grcs_pkg::ST_ROOT;
      iter_num      = '0;
      iter_den      = len_ff;
      case (state_ff)
         grcs_pkg::ST_SQ_X: begin
            mul_a = {2'b00, magx};
            mul_b = {2'b00, magx};
         end
         grcs_pkg::ST_SQ_Z: begin
            mul_a = {2'b00, magz};
            mul_b = {2'b00, magz};
         end
         grcs_pkg::ST_ROOT: begin
            iter_num = sqx_ff + prod_ff[63:0];
         end
         grcs_pkg::ST_DIV_X: begin
            iter_num = {16'h0, {1'b0, magx, 15'h0} + {17'h0, len_ff[31:1]}};
         end
         grcs_pkg::ST_DIV_Z: begin
            iter_num = {16'h0, {1'b0, magz, 15'h0} + {17'h0, len_ff[31:1]}};
         end
         grcs_pkg::ST_INV_X: begin
            iter_num = {32'h0, 32'h80000000 + {17'h0, mux[15:1]}};
            iter_den = {16'h0, mux};
         end
         grcs_pkg::ST_INV_Z: begin
            iter_num = {32'h0, 32'h80000000 + {17'h0, muz[15:1]}};
            iter_den = {16'h0, muz};
         end
         grcs_pkg::ST_EDGE_X: begin
            mul_a = {{18{req_ff.start_cell_x[15]}}, req_ff.start_cell_x}
                    + {33'h0, !ux_ff[15] && (ux_ff != 16'sd0)};
            mul_b = {3'b000, grid_ff};
         end
         grcs_pkg::ST_EDGE_Z: begin
            mul_a = {{18{req_ff.start_cell_y[15]}}, req_ff.start_cell_y}
                    + {33'h0, signs_ff[2]};
            mul_b = {3'b000, grid_ff};
         end
         grcs_pkg::ST_CAND_X: begin
            mul_a = {{2{invx_ff[31]}}, invx_ff};
            mul_b = {{2{edgex_ff[31]}}, edgex_ff};
         end
         grcs_pkg::ST_CAND_Z: begin
            mul_a = {{2{invz_ff[31]}}, invz_ff};
            mul_b = {{2{edgez_ff[31]}}, edgez_ff};
         end
         grcs_pkg::ST_MOVE_X: begin
            mul_a = {2'b00, travel_ff};
            mul_b = {18'h0, mux};
         end
         grcs_pkg::ST_MOVE_Z: begin
            mul_a = {2'b00, travel_ff};
            mul_b = {18'h0, muz};
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      logic signed [63:0] gx, gz, mx, mz;
      req_in      = accept ? req_data : req_ff;
      sqx_in      = sqx_ff;
      len_in      = len_ff;
      ux_in       = ux_ff;
      uz_in       = uz_ff;
      invx_in     = invx_ff;
      invz_in     = invz_ff;
      edgex_in    = edgex_ff;
      edgez_in    = edgez_ff;
      cellx_in    = cellx_ff;
      celly_in    = celly_ff;
      signs_in    = signs_ff;
      tx_in       = tx_ff;
      travel_in   = travel_ff;
      movex_in    = movex_ff;
      pickx_in    = pickx_ff;
      launched_in = iter_ctl.go ? 1'b1 : (iter_done ? 1'b0 : launched_ff);
      prod_in     = mul_a * mul_b;
      gx = '0;
      gz = '0;
      mx = '0;
      mz = '0;
      case (state_ff)
         grcs_pkg::ST_SQ_Z: sqx_in = prod_ff[63:0];
         grcs_pkg::ST_ROOT: if (iter_done) len_in = iter_res[31:0];
         grcs_pkg::ST_DIV_X: begin
            if (iter_done) ux_in = unit_from(iter_res, len_ff == 32'd0, req_ff.dir_x[31]);
         end
         grcs_pkg::ST_DIV_Z: begin
            if (iter_done) uz_in = unit_from(iter_res, len_ff == 32'd0, req_ff.dir_z[31]);
         end
         grcs_pkg::ST_INV_X: if (iter_done) invx_in = inv_from(iter_res, ux_ff);
         grcs_pkg::ST_INV_Z: if (iter_done) invz_in = inv_from(iter_res, uz_ff);
         grcs_pkg::ST_EDGE_X: begin
            signs_in = {uz_ff[15], !uz_ff[15] && (uz_ff != 16'sd0),
                        ux_ff[15], !ux_ff[15] && (ux_ff != 16'sd0)};
            cellx_in = req_ff.start_cell_x;
            celly_in = req_ff.start_cell_y;
         end
         grcs_pkg::ST_EDGE_Z: begin
            edgex_in = grcs_pkg::sat32(prod_ff[63:0] - {{32{req_ff.pos_x[31]}}, req_ff.pos_x});
         end
         grcs_pkg::ST_EDGE_DONE: begin
            edgez_in  = grcs_pkg::sat32(prod_ff[63:0] - {{32{req_ff.pos_z[31]}}, req_ff.pos_z});
            travel_in = 32'h0;
         end
         grcs_pkg::ST_CAND_Z: tx_in = grcs_pkg::cand(prod_ff[63:0], ux_ff != 16'sd0);
         grcs_pkg::ST_PICK: begin
            pickx_in = pick;
            if (pick) begin
               travel_in = tx_ff;
               cellx_in  = cellx_ff + (signs_ff[0] ? 16'd1 : (signs_ff[1] ? 16'hFFFF : 16'd0));
            end else begin
               travel_in = ty;
               celly_in  = celly_ff + (signs_ff[2] ? 16'd1 : (signs_ff[3] ? 16'hFFFF : 16'd0));
            end
         end
         grcs_pkg::ST_MOVE_Z: movex_in = prod_ff[46:15];
         grcs_pkg::ST_UPDATE: begin
            // crossed axis advances one cell edge, both lose the travelled share
            if (pickx_ff) begin
               gx = signs_ff[0] ? {33'h0, grid_ff} :
                    (signs_ff[1] ? -$signed({33'h0, grid_ff}) : 64'sd0);
            end else begin
               gz = signs_ff[2] ? {33'h0, grid_ff} :
                    (signs_ff[3] ? -$signed({33'h0, grid_ff}) : 64'sd0);
            end
            mx = ux_ff[15] ? -$signed({32'h0, movex_ff}) : $signed({32'h0, movex_ff});
            mz = uz_ff[15] ? -$signed({32'h0, prod_ff[46:15]})
                           : $signed({32'h0, prod_ff[46:15]});
            edgex_in = grcs_pkg::sat32({{32{edgex_ff[31]}}, edgex_ff} + gx - mx);
            edgez_in = grcs_pkg::sat32({{32{edgez_ff[31]}}, edgez_ff} + gz - mz);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= grcs_pkg::ST_IDLE;
         launched_ff <= 1'b0;
         grid_ff     <= grcs_pkg::GRID_RESET;
         ux_ff       <= '0;
         uz_ff       <= '0;
         invx_ff     <= '0;
         invz_ff     <= '0;
         edgex_ff    <= '0;
         edgez_ff    <= '0;
         cellx_ff    <= '0;
         celly_ff    <= '0;
         signs_ff    <= '0;
         travel_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         if (csr_write_en) begin
            grid_ff <= csr_write_data;
         end
         ux_ff       <= ux_in;
         uz_ff       <= uz_in;
         invx_ff     <= invx_in;
         invz_ff     <= invz_in;
         edgex_ff    <= edgex_in;
         edgez_ff    <= edgez_in;
         cellx_ff    <= cellx_in;
         celly_ff    <= celly_in;
         signs_ff    <= signs_in;
         travel_ff   <= travel_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      sqx_ff   <= sqx_in;
      len_ff   <= len_in;
      tx_ff    <= tx_in;
      movex_ff <= movex_in;
      pickx_ff <= pickx_in;
      prod_ff  <= prod_in;
   end

   assign rsp_data.cell_x          = cellx_ff;
   assign rsp_data.cell_y          = celly_ff;
   assign rsp_data.travel_distance = travel_ff;

   a_result_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result shown while input open");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != grcs_pkg::ST_IDLE))
      else $error("accepted item not worked on");

   a_done_only_when_launched: assert property (@(posedge clock) disable iff (reset)
      iter_done |-> launched_ff)
      else $error("iterative unit finished without a launch");

endmodule
